// ===== hw/rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, codes and helpers for the json string unescape unit
// ----------------------------------------------------------------------------
package jsu_pkg;

	// decoder phases
	localparam logic [1:0] PH_SEEK = 2'd0;
	localparam logic [1:0] PH_STR  = 2'd1;
	localparam logic [1:0] PH_ESC  = 2'd2;
	localparam logic [1:0] PH_HEX  = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_QUOTE   = 3'd1;
	localparam logic [2:0] ERR_UNTERM  = 3'd2;
	localparam logic [2:0] ERR_ESC_END = 3'd3;
	localparam logic [2:0] ERR_UNICODE = 3'd4;
	localparam logic [2:0] ERR_BADESC  = 3'd5;

	// characters
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_FF = 8'h0C;

	// input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} jsu_in_t;

	// output word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_done;
		logic [2:0] error_code;
	} jsu_out_t;

	// decoder state
	typedef struct packed {
		logic [1:0]  phase;
		logic [1:0]  hex_digits_seen;
		logic [15:0] code_accumulator;
	} jsu_state_t;

	localparam jsu_state_t STATE_RESET = '{phase: PH_SEEK, hex_digits_seen: 2'd0,
		code_accumulator: 16'd0};

	// hex digit value, bit 4 set when the byte is not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		v = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = {1'b0, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = {1'b0, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = {1'b0, 4'(b - 8'h37)};
		end
		return v;
	endfunction

endpackage

// ===== hw/rtl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode
// next-state and result logic for one input byte
// ----------------------------------------------------------------------------
module jsu_decode (
	input  jsu_pkg::jsu_state_t cur,
	input  jsu_pkg::jsu_in_t    item,
	output jsu_pkg::jsu_state_t nxt,
	output logic                has_result,
	output jsu_pkg::jsu_out_t   res
);
	import jsu_pkg::*;

	logic [7:0]  b;
	logic        eoi;
	logic [4:0]  hv;
	logic [15:0] acc;

	assign b   = item.data_byte;
	assign eoi = item.end_of_input;
	assign hv  = hex_value(b);
	assign acc = {cur.code_accumulator[11:0], hv[3:0]};

	always_comb begin
		nxt        = cur;
		has_result = 1'b0;
		res        = '0;
		unique case (cur.phase)
			PH_SEEK: begin
				if (eoi) begin
					has_result     = 1'b1;
					res.error_code = ERR_QUOTE;
					nxt            = STATE_RESET;
				end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
					nxt = cur;
				end else if (b == CH_QUOTE) begin
					nxt.phase = PH_STR;
				end else begin
					has_result     = 1'b1;
					res.error_code = ERR_QUOTE;
					nxt            = STATE_RESET;
				end
			end
			PH_STR: begin
				if (eoi) begin
					has_result     = 1'b1;
					res.error_code = ERR_UNTERM;
					nxt            = STATE_RESET;
				end else if (b == CH_QUOTE) begin
					has_result      = 1'b1;
					res.string_done = 1'b1;
					nxt.phase       = PH_SEEK;
				end else if (b == CH_BSLASH) begin
					nxt.phase = PH_ESC;
				end else begin
					has_result     = 1'b1;
					res.out_byte   = b;
					res.byte_valid = 1'b1;
				end
			end
			PH_ESC: begin
				if (eoi) begin
					has_result     = 1'b1;
					res.error_code = ERR_ESC_END;
					nxt            = STATE_RESET;
				end else if (b == 8'h75) begin
					// \u: start collecting four hex digits
					nxt.phase            = PH_HEX;
					nxt.hex_digits_seen  = 2'd0;
					nxt.code_accumulator = 16'd0;
				end else begin
					has_result     = 1'b1;
					res.byte_valid = 1'b1;
					nxt.phase      = PH_STR;
					unique case (b)
						CH_QUOTE:  res.out_byte = CH_QUOTE;
						CH_BSLASH: res.out_byte = CH_BSLASH;
						CH_SLASH:  res.out_byte = CH_SLASH;
						8'h62:     res.out_byte = CH_BS;
						8'h66:     res.out_byte = CH_FF;
						8'h6E:     res.out_byte = CH_LF;
						8'h72:     res.out_byte = CH_CR;
						8'h74:     res.out_byte = CH_TAB;
						default: begin
							res.byte_valid = 1'b0;
							res.error_code = ERR_BADESC;
							nxt            = STATE_RESET;
						end
					endcase
				end
			end
			PH_HEX: begin
				if (eoi || hv[4]) begin
					has_result     = 1'b1;
					res.error_code = ERR_UNICODE;
					nxt            = STATE_RESET;
				end else if (cur.hex_digits_seen == 2'd3) begin
					// fourth digit: non-ascii code points become '?'
					has_result     = 1'b1;
					res.byte_valid = 1'b1;
					res.out_byte   = (acc[15:7] == 9'd0) ? acc[7:0] : CH_QMARK;
					nxt            = STATE_RESET;
					nxt.phase      = PH_STR;
				end else begin
					nxt.code_accumulator = acc;
					nxt.hex_digits_seen  = cur.hex_digits_seen + 2'd1;
				end
			end
			default: nxt = STATE_RESET;
		endcase
	end

endmodule

// ===== hw/rtl/json_string_unescape_unit.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// streaming decoder for one json string literal, one byte per word
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                     word
//   item      in          item_valid / item_ready       jsu_in_t  (byte, end flag)
//   result    out         result_valid / result_ready   jsu_out_t (byte, flags, error)
//
// one input word per cycle sustained while the result register drains; a word is held in the input
// register, is decoded against the phase and \u accumulator, and its result
// (if any) lands in the result register the same edge the state updates.
// between acceptance and result valid lie the input register and then the
// result register.
// reset returns the decoder to seeking an opening quote and empties both
// registers.
// a stalled result register holds the decode stage; item_ready drops only
// when the input register is full and cannot move on.
//
module json_string_unescape_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  jsu_pkg::jsu_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output jsu_pkg::jsu_out_t result
);
	import jsu_pkg::*;

	// input register
	jsu_in_t    item_s1;
	logic       item_valid_s1;

	// decoder state
	jsu_state_t state_q;
	jsu_state_t state_nxt;

	// result register
	jsu_out_t   result_s2;
	logic       result_valid_s2;

	// decode outputs
	logic       has_result;
	jsu_out_t   res;

	logic       accept;
	logic       advance;

	// the decode stage moves when the result register is free or draining
	assign advance    = item_valid_s1 && (!result_valid_s2 || result_ready);
	assign item_ready = !item_valid_s1 || advance;
	assign accept     = item_valid && item_ready;

	jsu_decode u_decode (
		.cur        (state_q),
		.item       (item_s1),
		.nxt        (state_nxt),
		.has_result (has_result),
		.res        (res)
	);

	// input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	// phase, digit count and code point advance once per decoded word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_s2 <= res;
		end
	end

	// words that produce no result simply leave the result register alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance && has_result) begin
			result_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			result_valid_s2 <= 1'b0;
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

endmodule
